>>> rtl/mqd_pkg.sv
// shared codes, widths and result type for the max-tracking queue
package mqd_pkg;

  localparam int VAL_W = 32;
  localparam int REQ_W = 2;
  localparam int ST_W  = 2;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MAX = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] data;
  } res_t;

endpackage

>>> rtl/mqd_ram.sv
// generic single-write, single-read ram with registered read data
module mqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mqd_ctrl.sv
// sequencer: queue pointers, max deque pointers and the shared signed comparator
module mqd_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // capacity register
  input  logic                        cfg_we,
  input  logic [mqd_pkg::CAP_W-1:0]   cfg_wdata,
  // request side
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [mqd_pkg::REQ_W-1:0]   req_type,
  input  logic [mqd_pkg::VAL_W-1:0]   req_value,
  // result side
  output logic                        res_valid,
  input  logic                        res_ready,
  output mqd_pkg::res_t               res,
  // queue store
  output logic                        fifo_we,
  output logic [$clog2(DEPTH)-1:0]    fifo_waddr,
  output logic [mqd_pkg::VAL_W-1:0]   fifo_wdata,
  output logic [$clog2(DEPTH)-1:0]    fifo_raddr,
  input  logic [mqd_pkg::VAL_W-1:0]   fifo_rdata,
  // deque store
  output logic                        max_we,
  output logic [$clog2(DEPTH)-1:0]    max_waddr,
  output logic [mqd_pkg::VAL_W-1:0]   max_wdata,
  output logic [$clog2(DEPTH)-1:0]    max_raddr,
  input  logic [mqd_pkg::VAL_W-1:0]   max_rdata
);
  import mqd_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {S_IDLE, S_POP, S_DEQ, S_MAX, S_RESP} state_t;

  state_t             state, state_next;
  logic [CAP_W-1:0]   capacity;
  logic [VAL_W-1:0]   val, val_next;
  logic [AW-1:0]      fifo_head, fifo_head_next;
  logic [CW-1:0]      fifo_count, fifo_count_next;
  logic [AW-1:0]      max_head, max_head_next;
  logic [CW-1:0]      max_count, max_count_next;
  res_t               res_next;

  logic [CMPW-1:0]    cap_eff;
  logic               full;
  logic [CW-1:0]      cnt_dec;
  logic [AW-1:0]      tail, max_back, max_end, back_dec;
  logic               pop_back;

  // head plus offset, wrapped into the store; the sum stays below twice the depth
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // effective capacity saturates at the store depth
  assign cap_eff = (CMPW'(capacity) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(capacity);
  assign full    = CMPW'(fifo_count) >= cap_eff;

  // store addresses
  assign cnt_dec  = max_count - CW'(1);
  assign tail     = wrap_add(fifo_head, fifo_count);
  assign max_back = wrap_add(max_head, cnt_dec);
  assign max_end  = wrap_add(max_head, max_count);
  assign back_dec = wrap_add(max_head, cnt_dec - CW'(1));

  // the one comparator: deque back strictly below the new value
  assign pop_back = $signed(max_rdata) < $signed(val);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_RESP);

  // next state, pointer updates and store strobes
  always_comb begin
    state_next      = state;
    val_next        = val;
    fifo_head_next  = fifo_head;
    fifo_count_next = fifo_count;
    max_head_next   = max_head;
    max_count_next  = max_count;
    res_next        = res;
    fifo_we         = 1'b0;
    fifo_waddr      = tail;
    fifo_wdata      = req_value;
    fifo_raddr      = fifo_head;
    max_we          = 1'b0;
    max_waddr       = max_end;
    max_wdata       = val;
    max_raddr       = max_head;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          val_next        = req_value;
          res_next.status = ST_OK;
          res_next.data   = '0;
          state_next      = S_RESP;
          unique case (req_type)
            REQ_ENQ: begin
              if (full) begin
                res_next.status = ST_FULL;
              end else begin
                fifo_we         = 1'b1;
                fifo_count_next = fifo_count + CW'(1);
                if (max_count == '0) begin
                  max_we         = 1'b1;
                  max_waddr      = max_head;
                  max_wdata      = req_value;
                  max_count_next = CW'(1);
                end else begin
                  max_raddr  = max_back;
                  state_next = S_POP;
                end
              end
            end
            REQ_DEQ: begin
              if (fifo_count == '0) begin
                res_next.status = ST_EMPTY;
              end else begin
                state_next = S_DEQ;
              end
            end
            REQ_MAX: begin
              if (fifo_count == '0 || max_count == '0) begin
                res_next.status = ST_EMPTY;
              end else begin
                state_next = S_MAX;
              end
            end
            default: begin
              res_next.status = ST_OK;
            end
          endcase
        end
      end
      S_POP: begin
        // drop smaller entries from the back, one per cycle, then append the new value if there is room
        if (pop_back) begin
          max_count_next = cnt_dec;
          if (cnt_dec == '0) begin
            max_we         = 1'b1;
            max_waddr      = max_head;
            max_count_next = CW'(1);
            state_next     = S_RESP;
          end else begin
            max_raddr = back_dec;
          end
        end else begin
          if (max_count < CW'(DEPTH)) begin
            max_we         = 1'b1;
            max_waddr      = max_end;
            max_count_next = max_count + CW'(1);
          end
          state_next = S_RESP;
        end
      end
      S_DEQ: begin
        res_next.data   = fifo_rdata;
        fifo_head_next  = wrap_add(fifo_head, CW'(1));
        fifo_count_next = fifo_count - CW'(1);
        if (max_count != '0 && max_rdata == fifo_rdata) begin
          max_head_next  = wrap_add(max_head, CW'(1));
          max_count_next = cnt_dec;
        end
        state_next = S_RESP;
      end
      S_MAX: begin
        res_next.data = max_rdata;
        state_next    = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, pointers, capacity and result holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      capacity   <= CAP_RESET;
      fifo_head  <= '0;
      fifo_count <= '0;
      max_head   <= '0;
      max_count  <= '0;
    end else begin
      state      <= state_next;
      fifo_head  <= fifo_head_next;
      fifo_count <= fifo_count_next;
      max_head   <= max_head_next;
      max_count  <= max_count_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
    val <= val_next;
    res <= res_next;
  end

endmodule

>>> rtl/max_queue_monotonic_deque_top.sv
// top level of the bounded queue with running maximum
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  request  | in  | s_tvalid/s_tready  | s_tuser: req_type; s_tdata: value
//  result   | out | m_tvalid/m_tready  | m_tuser: status; m_tdata: data_out
//  capacity | in  | cfg_we             | cfg_wdata: capacity (5 bits)
//
//  enqueue compares the new value with deque entries from the back one at a time, as
//  the deque ram has a single read port feeding one signed comparator; dequeue and max
//  read pass through a read state, full, empty and unused codes go straight to the result
//  reset clears all pointers and counts and sets capacity to 16; store contents are
//  left as they are, no clearing pass
//  a finished result sits in the output register while the next request is taken;
//  a second result waits in the sequencer until the output register frees
module max_queue_monotonic_deque_top #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mqd_pkg::CAP_W-1:0] cfg_wdata,   // [4:0] capacity
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,     // [31:0] value
  input  logic [7:0]                s_tuser,     // [1:0] req_type
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata,     // [31:0] data_out
  output logic [7:0]                m_tuser      // [1:0] status
);
  import mqd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic             res_valid, res_ready;
  res_t             res;
  logic             fifo_we, max_we;
  logic [AW-1:0]    fifo_waddr, fifo_raddr, max_waddr, max_raddr;
  logic [VAL_W-1:0] fifo_wdata, fifo_rdata, max_wdata, max_rdata;
  logic [ST_W-1:0]  m_status;

  mqd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_type   (s_tuser[REQ_W-1:0]),
    .req_value  (s_tdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .fifo_we    (fifo_we),
    .fifo_waddr (fifo_waddr),
    .fifo_wdata (fifo_wdata),
    .fifo_raddr (fifo_raddr),
    .fifo_rdata (fifo_rdata),
    .max_we     (max_we),
    .max_waddr  (max_waddr),
    .max_wdata  (max_wdata),
    .max_raddr  (max_raddr),
    .max_rdata  (max_rdata)
  );

  // queue contents
  mqd_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  // non-increasing deque of candidate maxima
  mqd_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (max_waddr),
    .wdata (max_wdata),
    .raddr (max_raddr),
    .rdata (max_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_valid && res_ready) begin
      m_tdata  <= res.data;
      m_status <= res.status;
    end
  end

  assign m_tuser = {{(8-ST_W){1'b0}}, m_status};

endmodule

>>> rtl/mqd_checker.sv
// port-level checks for the max-tracking queue, bound to the top level
module mqd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [7:0]  m_tuser
);
  import mqd_pkg::*;

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // full and empty reports carry zero data, status is a defined code
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser[ST_W-1:0] == ST_OK) ||
                  ((m_tuser[ST_W-1:0] == ST_EMPTY || m_tuser[ST_W-1:0] == ST_FULL)
                   && m_tdata == '0)))
    else $error("bad status or nonzero data on a refusal");

  // the sequencer is busy right after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while the previous one is at work");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind max_queue_monotonic_deque_top mqd_checker u_mqd_checker (.*);
